/* rtl/slp_pkg.sv */
// types and constants shared by the signed low-bit packer
// no dependencies; compile first
package slp_pkg;

    localparam int C_BYTE_BITS = 8;

    // element width register limits and reset value
    localparam logic [2:0] C_WIDTH_MIN   = 3'd2;
    localparam logic [2:0] C_WIDTH_MID   = 3'd3;
    localparam logic [2:0] C_WIDTH_MAX   = 3'd4;
    localparam logic [2:0] C_WIDTH_RESET = 3'd4;

    // one queue entry: the beats one input item produces
    typedef struct packed {
        logic [7:0] data_a;
        logic       last_a;
        logic [7:0] data_b;
        logic       has_b;
    } t_entry;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

/* rtl/slp_if.sv */
// stream interfaces for the signed low-bit packer
// depends on nothing; compile after slp_pkg
interface slp_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] sample_value;
    logic              final_element;

    modport source (output valid, output sample_value, output final_element, input ready);
    modport sink   (input valid, input sample_value, input final_element, output ready);
endinterface

interface slp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       final_byte;

    modport source (output valid, output packed_byte, output final_byte, input ready);
    modport sink   (input valid, input packed_byte, input final_byte, output ready);
endinterface

/* rtl/slp_front.sv */
// front part: width register, clip and merge into pending bits, queue push
// depends on slp_pkg and slp_in_if
module slp_front
    import slp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    slp_in_if.sink     i_in_ch,
    input  t_fifo_stat i_stat,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [2:0]        r_width;
    logic [7:0]        r_pend_bits;
    logic [2:0]        r_pend_count;
    logic [7:0]        n_pend_bits;
    logic [2:0]        n_pend_count;
    logic [2:0]        w_eff;
    logic signed [7:0] w_hi;
    logic signed [7:0] w_lo;
    logic signed [7:0] w_clip;
    logic [3:0]        w_mask;
    logic [3:0]        w_code;
    logic [11:0]       w_merged;
    logic [3:0]        w_total;
    logic              w_full;
    logic              w_accept;

    // width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= C_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    // width clamped to the supported range
    always_comb begin
        if (r_width < C_WIDTH_MIN) begin
            w_eff = C_WIDTH_MIN;
        end else if (r_width > C_WIDTH_MAX) begin
            w_eff = C_WIDTH_MAX;
        end else begin
            w_eff = r_width;
        end
    end

    // saturate to the signed range of the width, then mask
    always_comb begin
        case (w_eff)
            C_WIDTH_MIN: begin
                w_hi   = 8'sd1;
                w_mask = 4'b0011;
            end
            C_WIDTH_MID: begin
                w_hi   = 8'sd3;
                w_mask = 4'b0111;
            end
            default: begin
                w_hi   = 8'sd7;
                w_mask = 4'b1111;
            end
        endcase
        w_lo = ~w_hi;
        if (i_in_ch.sample_value > w_hi) begin
            w_clip = w_hi;
        end else if (i_in_ch.sample_value < w_lo) begin
            w_clip = w_lo;
        end else begin
            w_clip = i_in_ch.sample_value;
        end
        w_code = w_clip[3:0] & w_mask;
    end

    // merge above the pending bits
    assign w_merged = {4'b0000, r_pend_bits} | ({8'h00, w_code} << r_pend_count);
    assign w_total  = {1'b0, r_pend_count} + {1'b0, w_eff};
    assign w_full   = w_total[3];

    assign i_in_ch.ready = !i_stat.full;
    assign w_accept      = i_in_ch.valid && !i_stat.full;

    // beats for the queue
    always_comb begin
        o_entry        = '0;
        o_entry.data_a = w_merged[7:0];
        o_push         = 1'b0;
        if (w_full) begin
            o_push         = w_accept;
            o_entry.last_a = i_in_ch.final_element && (w_total == 4'd8);
            o_entry.has_b  = i_in_ch.final_element && (w_total != 4'd8);
            o_entry.data_b = {4'b0000, w_merged[11:8]};
        end else if (i_in_ch.final_element && (w_total != 4'd0)) begin
            o_push         = w_accept;
            o_entry.last_a = 1'b1;
        end
    end

    // pending state after an accepted beat
    always_comb begin
        n_pend_bits  = r_pend_bits;
        n_pend_count = r_pend_count;
        if (w_accept) begin
            if (i_in_ch.final_element) begin
                n_pend_bits  = '0;
                n_pend_count = '0;
            end else begin
                n_pend_bits  = w_full ? {4'b0000, w_merged[11:8]} : w_merged[7:0];
                n_pend_count = w_total[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits  <= '0;
            r_pend_count <= '0;
        end else begin
            r_pend_bits  <= n_pend_bits;
            r_pend_count <= n_pend_count;
        end
    end

endmodule

/* rtl/slp_fifo.sv */
// short queue of pending output entries between front and back parts
// depends on slp_pkg
module slp_fifo
    import slp_pkg::*;
#(
    parameter int P_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_entry                       i_entry,
    input  logic                         i_pop,
    output t_entry                       o_head,
    output t_fifo_stat                   o_stat,
    output logic [$clog2(P_DEPTH+1)-1:0] o_level
);

    localparam int P_PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int P_LVL_W = $clog2(P_DEPTH + 1);

    t_entry             r_mem [P_DEPTH];
    logic [P_PTR_W-1:0] r_wr_ptr;
    logic [P_PTR_W-1:0] r_rd_ptr;
    logic [P_LVL_W-1:0] r_level;
    logic [P_PTR_W-1:0] n_wr_ptr;
    logic [P_PTR_W-1:0] n_rd_ptr;
    logic [P_LVL_W-1:0] n_level;
    logic               w_push;
    logic               w_pop;

    assign o_stat.full  = (r_level == P_LVL_W'(P_DEPTH));
    assign o_stat.empty = (r_level == '0);
    assign o_level      = r_level;
    assign o_head       = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    // pointer and level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == P_PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == P_PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_level = r_level + 1'b1;
        end else if (w_pop && !w_push) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/slp_back.sv */
// back part: steps through queued entries one beat at a time into the output register
// depends on slp_pkg and slp_out_if
module slp_back
    import slp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  t_fifo_stat i_stat,
    output logic       o_pop,
    slp_out_if.source  o_out_ch
);

    logic       r_sub;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       n_sub;
    logic       n_valid;
    logic [7:0] n_data;
    logic       n_last;
    logic       w_load;

    assign w_load = !r_valid || o_out_ch.ready;
    assign o_pop  = w_load && !i_stat.empty && (!i_head.has_b || r_sub);

    // choose the next beat from the head entry
    always_comb begin
        n_sub   = r_sub;
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        if (w_load) begin
            n_valid = !i_stat.empty;
            if (!i_stat.empty) begin
                n_data = r_sub ? i_head.data_b : i_head.data_a;
                n_last = r_sub ? 1'b1 : i_head.last_a;
                n_sub  = o_pop ? 1'b0 : 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_sub   <= n_sub;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_out_ch.valid       = r_valid;
    assign o_out_ch.packed_byte = r_data;
    assign o_out_ch.final_byte  = r_last;

endmodule

/* rtl/signed_low_bit_packer.sv */
// signed low-bit packer top level: front, queue and back parts
// depends on slp_pkg, slp_if, slp_front, slp_fifo, slp_back
//
// usage
//   i_in_ch takes one signed 8-bit sample per beat with a last-element flag.
//   each sample is saturated to element_width bits (2..4, clamped; reset 4),
//   packed lsb first, and a byte goes out on o_out_ch each time eight bits
//   gather. the last element flushes leftover bits as a zero-padded byte,
//   marked with final_byte.
//   i_cfg_we / i_cfg_wdata write element_width; write only while idle.
// throughput
//   one input beat per cycle while the queue has room; bytes pass the
//   queue, then the output register. an item flushing two bytes sends
//   both in turn; the output, one byte per cycle while ready, sets the rate.
// reset and stall
//   synchronous active-low reset clears pending bits, queue and output.
//   when the receiver stalls, the output register holds and the queue
//   (P_FIFO_DEPTH entries) absorbs input beats until full, then ready drops.
module signed_low_bit_packer
    import slp_pkg::*;
#(
    parameter int P_FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    slp_in_if.sink     i_in_ch,
    slp_out_if.source  o_out_ch
);

    localparam int P_LVL_W = $clog2(P_FIFO_DEPTH + 1);

    t_entry             w_push_entry;
    t_entry             w_head;
    t_fifo_stat         w_stat;
    logic               w_push;
    logic               w_pop;
    logic [P_LVL_W-1:0] w_level;

    slp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (i_in_ch),
        .i_stat      (w_stat),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    slp_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat),
        .o_level (w_level)
    );

    slp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_stat   (w_stat),
        .o_pop    (w_pop),
        .o_out_ch (o_out_ch)
    );

    // queue level never exceeds its depth
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= P_LVL_W'(P_FIFO_DEPTH))
        else $error("queue level above depth");

    // back part pops only a filled queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("pop from empty queue");

    // front part pushes only into a queue with room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("push into full queue");

    // output is idle right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_ch.valid)
        else $error("output valid after reset");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for signed_low_bit_packer: directed table, then random vectors
// depends on slp_pkg, slp_if and the rtl of signed_low_bit_packer
module testbench;
    import slp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 60;

    // one output beat: packed byte and its last-byte flag
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_out_beat;

    // one row of the directed table; known rows carry their bytes typed in
    typedef struct packed {
        logic [2:0] width;
        logic [7:0] value;
        logic       fin;
        logic       known;
        logic [1:0] n_bytes;
        logic [7:0] byte0;
        logic       fin0;
        logic [7:0] byte1;
        logic       fin1;
    } t_step_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [2:0] cfg_wdata;

    slp_in_if  in_ch ();
    slp_out_if out_ch ();

    signed_low_bit_packer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // packer state mirrored by the testbench
    logic [2:0] width_reg;
    logic [7:0] pend_bits;
    int         pend_cnt;
    t_out_beat  pred_beats [0:1];
    t_out_beat  bytes_due [$];
    t_step_row  typed_row;

    int         mismatches;
    int         cycles;
    bit         tx_idle;
    bit         rx_idle;
    bit         hold_request;

    // width, value, last, known, count, byte0, last0, byte1, last1
    t_step_row steps [0:22] = '{
        '{3'd4, 8'sd127,   1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd4, 8'sh80,    1'b0, 1'b1, 2'd1, 8'h87, 1'b0, 8'h00, 1'b0},
        '{3'd4, 8'sd5,     1'b1, 1'b1, 2'd1, 8'h05, 1'b1, 8'h00, 1'b0},
        '{3'd4, -8'sd1,    1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        // final element fills the byte exactly, no padded byte
        '{3'd4, 8'sd0,     1'b1, 1'b1, 2'd1, 8'h0F, 1'b1, 8'h00, 1'b0},
        '{3'd2, 8'sd1,     1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd2, -8'sd2,    1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd2, 8'sd100,   1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd2, -8'sd100,  1'b1, 1'b1, 2'd1, 8'h99, 1'b1, 8'h00, 1'b0},
        '{3'd2, 8'sd0,     1'b1, 1'b1, 2'd1, 8'h00, 1'b1, 8'h00, 1'b0},
        '{3'd3, 8'sd3,     1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd3, -8'sd4,    1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        // final element with leftover bits: full byte, then padded byte
        '{3'd3, -8'sd3,    1'b1, 1'b1, 2'd2, 8'h63, 1'b0, 8'h01, 1'b1},
        // widths out of range clamp to 2 and 4, changed mid-vector
        '{3'd0, 8'sd5,     1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd1, -8'sd5,    1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd7, 8'sd7,     1'b0, 1'b1, 2'd1, 8'h79, 1'b0, 8'h00, 1'b0},
        '{3'd5, -8'sd9,    1'b1, 1'b1, 2'd1, 8'h08, 1'b1, 8'h00, 1'b0},
        '{3'd6, 8'sd0,     1'b1, 1'b1, 2'd1, 8'h00, 1'b1, 8'h00, 1'b0},
        '{3'd3, 8'sd127,   1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd3, 8'sh80,    1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd2, -8'sd50,   1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd4, -8'sd7,    1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{3'd3, 8'sd0,     1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    logic [2:0] phase_width [0:PHASES-1] = '{
        C_WIDTH_MIN, C_WIDTH_MAX, C_WIDTH_MID, 3'd0, 3'd7,
        C_WIDTH_MAX, 3'd1, 3'd5, 3'd6, C_WIDTH_MID
    };

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // clip one sample, append it and return the bytes it completes
    function automatic int advance_packer(input logic signed [7:0] val, input logic fin);
        int unsigned eff_w;
        int          v;
        int          hi;
        int          lo;
        int          merged;
        int          total;
        int          n;
        if (width_reg < C_WIDTH_MIN)
            eff_w = C_WIDTH_MIN;
        else if (width_reg > C_WIDTH_MAX)
            eff_w = C_WIDTH_MAX;
        else
            eff_w = width_reg;
        v  = val;
        hi = (1 << (eff_w - 1)) - 1;
        lo = -hi - 1;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        merged = pend_bits | ((v & ((1 << eff_w) - 1)) << pend_cnt);
        total  = pend_cnt + eff_w;
        n      = 0;
        if (total >= C_BYTE_BITS) begin
            pred_beats[0] = '{merged[7:0], fin && (total == C_BYTE_BITS)};
            n      = 1;
            merged = merged >> C_BYTE_BITS;
            total  = total - C_BYTE_BITS;
        end
        if (fin) begin
            if (total > 0) begin
                pred_beats[n] = '{merged[7:0], 1'b1};
                n++;
            end
            pend_bits = '0;
            pend_cnt  = 0;
        end else begin
            pend_bits = merged[7:0];
            pend_cnt  = total;
        end
        return n;
    endfunction

    // one sample per call; sender gap drawn per beat
    task automatic send_sample(input t_step_row row);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        typed_row            = row;
        in_ch.valid         <= 1'b1;
        in_ch.sample_value  <= row.value;
        in_ch.final_element <= row.fin;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stop sending and wait until every byte owed has come out
    task automatic drain_pipeline();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [2:0] w);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly full-range values, some at the clip bounds
    function automatic logic [7:0] pick_sample();
        logic [7:0] s;
        case ($urandom_range(0, 5))
            0: s = ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F;
            1: s = 8'(int'($urandom_range(0, 17)) - 9);
            default: s = 8'($urandom_range(0, 255));
        endcase
        return s;
    endfunction

    // prediction on input beats, checking on output beats
    always @(posedge i_clk) begin : monitor
        int        n;
        t_out_beat want;
        if (!i_rst_n) begin
            width_reg = C_WIDTH_RESET;
            pend_bits = '0;
            pend_cnt  = 0;
            bytes_due.delete();
        end else begin
            if (cfg_we)
                width_reg = cfg_wdata;
            if (in_ch.valid && in_ch.ready) begin
                n = advance_packer(in_ch.sample_value, in_ch.final_element);
                if (typed_row.known) begin
                    if (typed_row.n_bytes > 0)
                        bytes_due.push_back('{typed_row.byte0, typed_row.fin0});
                    if (typed_row.n_bytes > 1)
                        bytes_due.push_back('{typed_row.byte1, typed_row.fin1});
                end else begin
                    for (int i = 0; i < n; i++)
                        bytes_due.push_back(pred_beats[i]);
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                if (bytes_due.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                             $time, out_ch.packed_byte, out_ch.final_byte);
                    mismatches++;
                end else begin
                    want = bytes_due.pop_front();
                    if (out_ch.packed_byte !== want.data) begin
                        $display("%0t: packed_byte expected %02h actual %02h",
                                 $time, want.data, out_ch.packed_byte);
                        mismatches++;
                    end
                    if (out_ch.final_byte !== want.fin) begin
                        $display("%0t: final_byte expected %0b actual %0b",
                                 $time, want.fin, out_ch.final_byte);
                        mismatches++;
                    end
                end
            end
        end
    end

    // receiver: random stall per beat, one long hold-off on request
    initial begin : receiver
        int unsigned stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_idle ? $urandom_range(0, 13) : 0;
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            @(negedge i_clk);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        t_step_row  row;
        logic [2:0] cur_width;
        int         vec_left;
        bit         noisy;
        in_ch.valid         = 1'b0;
        in_ch.sample_value  = '0;
        in_ch.final_element = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        i_rst_n             = 1'b0;
        typed_row           = '0;
        mismatches          = 0;
        cycles              = 0;
        tx_idle             = 1'b1;
        rx_idle             = 1'b1;
        hold_request        = 1'b0;
        cur_width           = C_WIDTH_RESET;
        vec_left            = 0;
        noisy               = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, width written between rows only when idle
        for (int r = 0; r < $size(steps); r++) begin
            if (steps[r].width != cur_width) begin
                drain_pipeline();
                set_width(steps[r].width);
                cur_width = steps[r].width;
            end
            send_sample(steps[r]);
        end

        // random vectors, a new width per phase, phases may cut a vector
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pipeline();
            set_width(phase_width[ph]);
            case (ph % 4)
                0: begin tx_idle = 1'b1; rx_idle = 1'b1; end
                1: begin tx_idle = 1'b0; rx_idle = 1'b0; end
                2: begin tx_idle = 1'b1; rx_idle = 1'b0; end
                default: begin tx_idle = 1'b0; rx_idle = 1'b1; end
            endcase
            // receiver holds off while samples keep coming, so the queue fills
            if (ph == 5) begin
                tx_idle      = 1'b0;
                hold_request = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (vec_left == 0) begin
                    vec_left = $urandom_range(1, 24);
                    noisy    = ($urandom_range(0, 5) == 0);
                end
                row       = '0;
                row.value = pick_sample();
                row.fin   = noisy ? ($urandom_range(0, 3) == 0) : (vec_left == 1);
                vec_left--;
                send_sample(row);
            end
        end

        drain_pipeline();
        if (mismatches == 0 && bytes_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
